### rtl/core/lcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared widths, types and helper functions of the Luhn card number checker.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int IN_WIDTH     = 54;
    localparam int BCD_DIGITS   = 17;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int STEP_BITS    = 6;
    localparam int N_STAGES     = IN_WIDTH / STEP_BITS;
    localparam int SUM_W        = 8;
    localparam int COUNT_W      = 5;
    localparam int MAX_DIGITS_D = 16;

    localparam logic [1:0] BRAND_INVALID    = 2'd0;
    localparam logic [1:0] BRAND_AMEX       = 2'd1;
    localparam logic [1:0] BRAND_VISA       = 2'd2;
    localparam logic [1:0] BRAND_MASTERCARD = 2'd3;

    typedef struct packed {
        logic [IN_WIDTH-1:0] bin;
        logic [BCD_W-1:0]    bcd;
    } dabble_t;

    // contribution of a digit at an odd index from the right, counting from zero
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [3:0] r;
        unique case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // remainder by ten for sums below 160
    function automatic logic [3:0] mod_ten(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] v;
        v = s;
        if (v >= SUM_W'(80)) v = v - SUM_W'(80);
        if (v >= SUM_W'(40)) v = v - SUM_W'(40);
        if (v >= SUM_W'(20)) v = v - SUM_W'(20);
        if (v >= SUM_W'(10)) v = v - SUM_W'(10);
        return v[3:0];
    endfunction

endpackage

### rtl/core/luhn_card_number_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_number_check
// Luhn mod-10 check, digit count and brand of a binary card number.
// ----------------------------------------------------------------------------
// One card number is taken per cycle and one result leaves per cycle while
// the result side does not stall. Each request passes 9 stages of the binary
// to decimal converter, which shifts 6 bits per stage with add-three
// correction, then one stage for digit count, Luhn sum and prefix tests and
// one for the checksum verdict and brand into the result register. A stall
// on the result side holds each full stage; empty stages still fill.
// Numbers with more than MAX_DIGITS digits give an all-zero result.
module luhn_card_number_check #(
    parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         card_valid,
    output logic                         card_stall,
    input  logic [lcc_pkg::IN_WIDTH-1:0] card_number,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [1:0]                   brand,
    output logic                         luhn_ok,
    output logic [lcc_pkg::COUNT_W-1:0]  digit_count
);
    import lcc_pkg::*;

    logic    stg_valid [N_STAGES+1];
    logic    stg_stall [N_STAGES+1];
    dabble_t stg_data  [N_STAGES+1];

    assign stg_valid[0]     = card_valid;
    assign card_stall       = stg_stall[0];
    assign stg_data[0].bin  = card_number;
    assign stg_data[0].bcd  = '0;

    for (genvar k = 0; k < N_STAGES; k++)
    begin : g_dabble
        lcc_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_stall  (stg_stall[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_stall (stg_stall[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    lcc_classify #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stg_valid[N_STAGES]),
        .in_stall    (stg_stall[N_STAGES]),
        .bcd         (stg_data[N_STAGES].bcd),
        .out_valid   (result_valid),
        .out_stall   (result_stall),
        .brand       (brand),
        .luhn_ok     (luhn_ok),
        .digit_count (digit_count)
    );

`ifndef SYNTHESIS
    // a brand is given only to numbers that pass the checksum
    a_brand_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (brand != BRAND_INVALID) |-> luhn_ok)
        else $error("brand set on failed checksum");

    a_amex_len: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (brand == BRAND_AMEX) |-> (digit_count == COUNT_W'(15)))
        else $error("amex brand with wrong length");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (digit_count <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count above limit");

    // a held result stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(brand)
        && $stable(luhn_ok) && $stable(digit_count))
        else $error("stalled result changed");
`endif

endmodule

### rtl/core/lcc_dabble_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_dabble_stage
// One registered stage of the binary to decimal converter: shifts a few
// binary bits into the decimal digits with the add-three correction.
// ----------------------------------------------------------------------------
module lcc_dabble_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lcc_pkg::dabble_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output lcc_pkg::dabble_t out_data
);
    import lcc_pkg::*;

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int i = 0; i < BCD_DIGITS; i++)
            begin
                if (data_next.bcd[4*i +: 4] >= 4'd5)
                begin
                    data_next.bcd[4*i +: 4] = data_next.bcd[4*i +: 4] + 4'd3;
                end
            end
            data_next.bcd = {data_next.bcd[BCD_W-2:0], data_next.bin[IN_WIDTH-1]};
            data_next.bin = {data_next.bin[IN_WIDTH-2:0], 1'b0};
        end
    end

    assign in_stall = valid_reg & out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/lcc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcc_classify
// Digit count, Luhn sum, prefix tests, then checksum verdict and brand into
// the result register.
// ----------------------------------------------------------------------------
module lcc_classify #(
    parameter int MAX_DIGITS = lcc_pkg::MAX_DIGITS_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lcc_pkg::BCD_W-1:0]   bcd,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  brand,
    output logic                        luhn_ok,
    output logic [lcc_pkg::COUNT_W-1:0] digit_count
);
    import lcc_pkg::*;

    // first stage: sum, count and prefix flags
    logic               a_valid_reg;
    logic               a_stall;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               over_reg, over_next;
    logic               amex_reg, amex_next;
    logic               mc_reg, mc_next;
    logic               visa_reg, visa_next;

    // second stage: result register
    logic               b_valid_reg;
    logic [1:0]         brand_reg, brand_next;
    logic               ok_reg, ok_next;
    logic [COUNT_W-1:0] dcount_reg, dcount_next;

    always_comb
    begin
        logic [3:0] d;
        sum_next   = '0;
        count_next = '0;
        over_next  = 1'b0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            d = bcd[4*i +: 4];
            if (d != 4'd0)
            begin
                count_next = COUNT_W'(i + 1);
                if (i >= MAX_DIGITS)
                begin
                    over_next = 1'b1;
                end
            end
            if (i % 2 == 1)
            begin
                sum_next = sum_next + SUM_W'(luhn_double(d));
            end
            else
            begin
                sum_next = sum_next + SUM_W'(d);
            end
        end
        amex_next = (count_next == COUNT_W'(15)) && (bcd[4*14 +: 4] == 4'd3)
                    && ((bcd[4*13 +: 4] == 4'd4) || (bcd[4*13 +: 4] == 4'd7));
        mc_next   = (count_next == COUNT_W'(16)) && (bcd[4*15 +: 4] == 4'd5)
                    && (bcd[4*14 +: 4] >= 4'd1) && (bcd[4*14 +: 4] <= 4'd5);
        visa_next = ((count_next == COUNT_W'(13)) && (bcd[4*12 +: 4] == 4'd4))
                    || ((count_next == COUNT_W'(16)) && (bcd[4*15 +: 4] == 4'd4));
    end

    assign a_stall  = b_valid_reg & out_stall;
    assign in_stall = a_valid_reg & a_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            over_reg  <= over_next;
            amex_reg  <= amex_next;
            mc_reg    <= mc_next;
            visa_reg  <= visa_next;
        end
    end

    always_comb
    begin
        ok_next     = (mod_ten(sum_reg) == 4'd0);
        dcount_next = count_reg;
        brand_next  = BRAND_INVALID;
        if (ok_next)
        begin
            priority if (amex_reg)
            begin
                brand_next = BRAND_AMEX;
            end
            else if (mc_reg)
            begin
                brand_next = BRAND_MASTERCARD;
            end
            else if (visa_reg)
            begin
                brand_next = BRAND_VISA;
            end
            else
            begin
                brand_next = BRAND_INVALID;
            end
        end
        // too many digits clears the whole result
        if (over_reg)
        begin
            ok_next     = 1'b0;
            dcount_next = '0;
            brand_next  = BRAND_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (!a_stall)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && !a_stall)
        begin
            brand_reg  <= brand_next;
            ok_reg     <= ok_next;
            dcount_reg <= dcount_next;
        end
    end

    assign out_valid   = b_valid_reg;
    assign brand       = brand_reg;
    assign luhn_ok     = ok_reg;
    assign digit_count = dcount_reg;

endmodule
